// ===== design/escape_string_decoder_fnv_hash_assert.svh =====
// Assertion macros for the escape string decoder with FNV-1a hash.
`ifndef ESCAPE_STRING_DECODER_FNV_HASH_ASSERT_SVH
`define ESCAPE_STRING_DECODER_FNV_HASH_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check cons in the same cycle as ante.
`define ESDFNV_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("esdfnv assertion failed");
// Check cons in the cycle after ante.
`define ESDFNV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("esdfnv assertion failed");
`else
`define ESDFNV_ASSERT_SAME(label, ante, cons)
`define ESDFNV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/esdfnv_pkg.sv =====
// Package: types, constants and helpers of the escape string decoder.
`timescale 1ns / 1ps
package esdfnv_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int LEN_OUT_BITS = 16;
   localparam int WIDE_BITS = LENGTH_BITS + LEN_OUT_BITS;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CTRL_NEWLINE   = 8'h0A;
   localparam logic [7:0] CTRL_RETURN    = 8'h0D;
   localparam logic [7:0] CTRL_TAB       = 8'h09;

   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};
   localparam logic [LEN_OUT_BITS-1:0] LEN_OUT_MAX = {LEN_OUT_BITS{1'b1}};

   typedef enum logic [3:0] {
      MODE_NORMAL   = 4'b0001,
      MODE_ESCAPE   = 4'b0010,
      MODE_HEX_HIGH = 4'b0100,
      MODE_HEX_LOW  = 4'b1000
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [3:0]             high_nibble;
      logic                   error;
      logic [31:0]            hash;
      logic [LENGTH_BITS-1:0] count;
   } state_type;

   typedef struct packed {
      logic [7:0]              out_byte;
      logic                    byte_valid;
      logic                    end_of_string;
      logic                    status;
      logic [31:0]             hash_value;
      logic [LEN_OUT_BITS-1:0] decoded_length;
   } result_type;

   localparam state_type STATE_RESET = '{
      mode:        MODE_NORMAL,
      high_nibble: 4'h0,
      error:       1'b0,
      hash:        FNV_BASIS,
      count:       '0
   };

   // Hex digit decode: bit 4 flags a valid digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_digit(logic [7:0] c);
      logic [4:0] r;
      r = 5'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // Saturate the internal count to the width of the length field.
   function automatic logic [LEN_OUT_BITS-1:0] length_out(logic [LENGTH_BITS-1:0] n);
      logic [WIDE_BITS-1:0] wide;
      wide = WIDE_BITS'(n);
      if (wide > WIDE_BITS'(LEN_OUT_MAX)) begin
         return LEN_OUT_MAX;
      end
      return wide[LEN_OUT_BITS-1:0];
   endfunction

endpackage

// ===== design/esdfnv_req_if.sv =====
// Input channel interface: raw source bytes with an end-of-string flag.
`timescale 1ns / 1ps
interface esdfnv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       is_last;

   modport source (output valid, output char_byte, output is_last, input ready);
   modport sink (input valid, input char_byte, input is_last, output ready);
endinterface

// ===== design/esdfnv_rsp_if.sv =====
// Result channel interface: decoded bytes and end-of-string summary.
`timescale 1ns / 1ps
interface esdfnv_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        end_of_string;
   logic        status;
   logic [31:0] hash_value;
   logic [15:0] decoded_length;

   modport source (output valid, output out_byte, output byte_valid, output end_of_string,
                   output status, output hash_value, output decoded_length, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input end_of_string,
                 input status, input hash_value, input decoded_length, output ready);
endinterface

// ===== design/esdfnv_step.sv =====
// Decode step: next decoder state and the result for one source byte.
`timescale 1ns / 1ps
module esdfnv_step
   import esdfnv_pkg::*;
(
   input  state_type  cur_state,
   input  logic [7:0] char_byte,
   input  logic       is_last,
   output state_type  next_state,
   output logic       emit,
   output result_type result
);

   logic       have;
   logic [7:0] dec_byte;
   logic [4:0] hex;
   logic       bad;
   state_type  upd;

   always_comb begin
      hex      = hex_digit(char_byte);
      upd      = cur_state;
      have     = 1'b0;
      dec_byte = 8'h00;
      if (!cur_state.error) begin
         unique case (cur_state.mode)
            MODE_NORMAL: begin
               if (char_byte == CHAR_BACKSLASH) begin
                  upd.mode = MODE_ESCAPE;
               end else begin
                  dec_byte = char_byte;
                  have     = 1'b1;
               end
            end
            MODE_ESCAPE: begin
               upd.mode = MODE_NORMAL;
               unique case (char_byte) inside
                  CHAR_BACKSLASH, CHAR_QUOTE, CHAR_DQUOTE: begin
                     dec_byte = char_byte;
                     have     = 1'b1;
                  end
                  CHAR_N: begin
                     dec_byte = CTRL_NEWLINE;
                     have     = 1'b1;
                  end
                  CHAR_R: begin
                     dec_byte = CTRL_RETURN;
                     have     = 1'b1;
                  end
                  CHAR_T: begin
                     dec_byte = CTRL_TAB;
                     have     = 1'b1;
                  end
                  CHAR_X: begin
                     upd.mode = MODE_HEX_HIGH;
                  end
                  default: begin
                     upd.error = 1'b1;
                  end
               endcase
            end
            MODE_HEX_HIGH: begin
               if (hex[4]) begin
                  upd.high_nibble = hex[3:0];
                  upd.mode        = MODE_HEX_LOW;
               end else begin
                  upd.error = 1'b1;
                  upd.mode  = MODE_NORMAL;
               end
            end
            MODE_HEX_LOW: begin
               if (hex[4]) begin
                  dec_byte = {cur_state.high_nibble, hex[3:0]};
                  have     = 1'b1;
               end else begin
                  upd.error = 1'b1;
               end
               upd.mode = MODE_NORMAL;
            end
            default: begin
               upd.mode = MODE_NORMAL;
            end
         endcase
      end

      // Fold the decoded byte into the hash and the saturating count.
      if (have) begin
         upd.hash = (cur_state.hash ^ {24'h000000, dec_byte}) * FNV_PRIME;
         if (cur_state.count != COUNT_MAX) begin
            upd.count = cur_state.count + LENGTH_BITS'(1);
         end
      end

      bad  = upd.error || (upd.mode != MODE_NORMAL);
      emit = have || is_last;

      result.out_byte       = dec_byte;
      result.byte_valid     = have;
      result.end_of_string  = is_last;
      result.status         = is_last && bad;
      result.hash_value     = (is_last && !bad) ? upd.hash : 32'h00000000;
      result.decoded_length = (is_last && !bad) ? length_out(upd.count) : '0;

      next_state = is_last ? STATE_RESET : upd;
   end

endmodule

// ===== design/escape_string_decoder_fnv_hash.sv =====
// Top level: streaming backslash-escape decoder with FNV-1a hash and length.
`timescale 1ns / 1ps
// Takes one raw byte of an escaped string literal per item, with is_last on the
// final byte, and gives back decoded bytes as they complete. The escapes \\ \'
// \" \n \r \t and \x with two hex digits of either case are decoded; any other
// byte passes through. An unknown escape letter, a bad hex digit or a string
// that ends inside an escape sets a sticky error, after which bytes are
// dropped until the final one. The final byte always yields an item with
// end_of_string set; with status 0 it carries the FNV-1a hash of the decoded
// bytes and their count (saturating at 65535), with status 1 both are zero.
// After that item the decoder starts a new string. Rate: one item per cycle
// while the result channel is ready; an accepted byte goes through the input
// register, then the result register. The clock is set by the decode step plus
// the 32-bit FNV multiply, from the hash register back to itself per decoded
// byte. No clearing pass: items are taken from the first cycle out of reset.
module escape_string_decoder_fnv_hash
   import esdfnv_pkg::*;
(
   input logic          clock,
   input logic          reset,
   esdfnv_req_if.sink   req_chan,
   esdfnv_rsp_if.source rsp_chan
);

`include "escape_string_decoder_fnv_hash_assert.svh"

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Decoder state carried from byte to byte.
   state_type  state_ff, state_in;

   // Result register.
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   state_type  step_state;
   logic       step_emit;
   result_type step_result;
   logic       out_space;
   logic       consume;
   logic       req_take;

   esdfnv_step u_step (
      .cur_state  (state_ff),
      .char_byte  (in_byte_ff),
      .is_last    (in_last_ff),
      .next_state (step_state),
      .emit       (step_emit),
      .result     (step_result)
   );

   // The result register is free when empty or being taken this cycle.
   assign out_space = !out_valid_ff || rsp_chan.ready;
   // Retire the held item: items without a result need no room downstream.
   assign consume   = in_valid_ff && (!step_emit || out_space);
   assign req_chan.ready = !in_valid_ff || consume;
   assign req_take  = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !consume);
      state_in     = consume ? step_state : state_ff;
      out_valid_in = (consume && step_emit) || (out_valid_ff && !rsp_chan.ready);
   end

   // Control state: valids and decoder state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.char_byte;
         in_last_ff <= req_chan.is_last;
      end
      if (consume && step_emit) begin
         out_ff <= step_result;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.out_byte       = out_ff.out_byte;
   assign rsp_chan.byte_valid     = out_ff.byte_valid;
   assign rsp_chan.end_of_string  = out_ff.end_of_string;
   assign rsp_chan.status         = out_ff.status;
   assign rsp_chan.hash_value     = out_ff.hash_value;
   assign rsp_chan.decoded_length = out_ff.decoded_length;

   // A result item always carries a byte or closes a string.
   `ESDFNV_ASSERT_SAME(a_no_empty_result, out_valid_ff, out_ff.byte_valid || out_ff.end_of_string)
   // Summary fields stay zero except on a clean end of string.
   `ESDFNV_ASSERT_SAME(a_summary_zero, out_valid_ff && (!out_ff.end_of_string || out_ff.status),
      out_ff.hash_value == 32'h00000000 && out_ff.decoded_length == '0)
   // An error always leaves the decoder in normal mode.
   `ESDFNV_ASSERT_SAME(a_error_mode, state_ff.error, state_ff.mode == MODE_NORMAL)
   // Closing a string restores the reset state.
   `ESDFNV_ASSERT_NEXT(a_clear_after_end, consume && in_last_ff,
      state_ff.mode == MODE_NORMAL && !state_ff.error && state_ff.count == '0)

endmodule
